### rtl/dlks_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlks_pkg
// Shared widths, seed reset values, register indexes and the unrolled
// transition masks of the 11-bit shift register.
// ----------------------------------------------------------------------------
package dlks_pkg;

  localparam int WORD_W      = 64;
  localparam int SHORT_W     = 11;
  localparam int LONG_W      = 2 * WORD_W;
  localparam int CFG_INDEX_W = 2;

  // Stream of the short register: the 11 seed bits, then one new bit per step.
  localparam int SHORT_STREAM_LEN = WORD_W + SHORT_W;

  localparam logic [SHORT_W-1:0] SHORT_SEED_RESET     = 11'd1023;
  localparam logic [WORD_W-1:0]  LONG_SEED_HIGH_RESET = 64'd13523568565465;
  localparam logic [WORD_W-1:0]  LONG_SEED_LOW_RESET  = 64'd54266675758343421;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SHORT_SEED     = 2'd0,
    REG_LONG_SEED_HIGH = 2'd1,
    REG_LONG_SEED_LOW  = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [SHORT_W-1:0] short_reg;
    logic [WORD_W-1:0]  long_high;
    logic [WORD_W-1:0]  long_low;
  } lfsr_state_t;

  typedef logic [SHORT_W-1:0] short_mask_t;
  typedef logic [SHORT_STREAM_LEN-1:0][SHORT_W-1:0] short_mask_arr_t;

  // Entry n tells which bits of the current short register XOR together to
  // give stream bit n. Bits 0..10 are the register itself, MSB first; each
  // later bit is y[n-10] ^ y[n-7] (old bit 9 ^ old bit 6).
  function automatic short_mask_arr_t short_masks();
    short_mask_arr_t m;
    m = '0;
    for (int n = 0; n < SHORT_STREAM_LEN; n++) begin
      if (n < SHORT_W) begin
        m[n] = short_mask_t'(1) << (SHORT_W - 1 - n);
      end else begin
        m[n] = m[n-10] ^ m[n-7];
      end
    end
    return m;
  endfunction

  localparam short_mask_arr_t SHORT_MASKS = short_masks();

endpackage

### rtl/dual_lfsr_keystream_cipher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_lfsr_keystream_cipher
// Stream cipher: each 64-bit beat is XORed with 64 keystream bits from an
// 11-bit and a 128-bit shift register.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries plain words in, m_* carries cipher words out; the same
//   operation decrypts. The first keystream bit of a word lands in bit 63.
//   cfg_* writes the seeds: index 0 short seed (low 11 bits kept), index 1
//   upper and index 2 lower word of the long seed. Every seed write reloads
//   both registers from all three seeds, restarting the keystream; unknown
//   indexes are dropped. Write seeds only while no beat is in flight.
// Throughput:
//   Each input beat is registered into the output register; one beat per
//   cycle sustained while m_tready is high. The keystream for a whole word
//   and the register state 64 steps on are flat XOR networks from the
//   register state, so an accepted beat moves the registers a full word on.
// Reset:
//   rst loads the default seeds into the seed and state registers and empties
//   the output register. Both ready outputs are low while rst is high.
// Stall:
//   The output register holds its beat while m_tready is low; s_tready then
//   drops, so at most one word waits and no keystream is consumed meanwhile.
// ----------------------------------------------------------------------------
module dual_lfsr_keystream_cipher
  import dlks_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  // input stream
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [WORD_W-1:0]      s_tdata,   // [63:0] plain_word
  // output stream
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [WORD_W-1:0]      m_tdata,   // [63:0] cipher_word
  // seed register writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]      cfg_data
);

  logic [SHORT_W-1:0] short_seed;
  logic [WORD_W-1:0]  long_seed_high;
  logic [WORD_W-1:0]  long_seed_low;

  lfsr_state_t        state;
  lfsr_state_t        state_next;
  logic [WORD_W-1:0]  keystream;

  logic               in_beat;
  logic               cfg_write;

  assign s_tready  = !rst && (!m_tvalid || m_tready);
  assign cfg_ready = !rst;
  assign in_beat   = s_tvalid && s_tready;
  assign cfg_write = cfg_valid && cfg_ready;

  dlks_keystream u_keystream (
    .state      (state),
    .keystream  (keystream),
    .state_next (state_next)
  );

  // Seed registers and shift register state. A seed write reloads the state
  // from the seeds as they stand after this write.
  always_ff @(posedge clk) begin
    if (rst) begin
      short_seed      <= SHORT_SEED_RESET;
      long_seed_high  <= LONG_SEED_HIGH_RESET;
      long_seed_low   <= LONG_SEED_LOW_RESET;
      state.short_reg <= SHORT_SEED_RESET;
      state.long_high <= LONG_SEED_HIGH_RESET;
      state.long_low  <= LONG_SEED_LOW_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SHORT_SEED: begin
          short_seed      <= cfg_data[SHORT_W-1:0];
          state.short_reg <= cfg_data[SHORT_W-1:0];
          state.long_high <= long_seed_high;
          state.long_low  <= long_seed_low;
        end
        REG_LONG_SEED_HIGH: begin
          long_seed_high  <= cfg_data;
          state.short_reg <= short_seed;
          state.long_high <= cfg_data;
          state.long_low  <= long_seed_low;
        end
        REG_LONG_SEED_LOW: begin
          long_seed_low   <= cfg_data;
          state.short_reg <= short_seed;
          state.long_high <= long_seed_high;
          state.long_low  <= cfg_data;
        end
        default: begin
          // unknown index: drop the write
        end
      endcase
    end else if (in_beat) begin
      // advance both registers by one full word
      state <= state_next;
    end
  end

  // Output register: load on every input beat, clear once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_beat) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      m_tdata <= s_tdata ^ keystream;
    end
  end

endmodule

### rtl/dlks_keystream.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlks_keystream
// Flat XOR networks for 64 steps of both shift registers: the keystream word
// and the register state that follows it.
// ----------------------------------------------------------------------------
module dlks_keystream
  import dlks_pkg::*;
(
  input  lfsr_state_t       state,
  output logic [WORD_W-1:0] keystream,
  output lfsr_state_t       state_next
);

  logic [LONG_W-1:0] wide;

  assign wide = {state.long_high, state.long_low};

  // Step t lands in bit 63-t. The long part reads seed bits 97-t and 91-t
  // directly, since no fed-back bit reaches those taps within 64 steps.
  always_comb begin
    for (int t = 0; t < WORD_W; t++) begin
      keystream[WORD_W-1-t] = (^((SHORT_MASKS[t] ^ SHORT_MASKS[t+3]) & state.short_reg))
                            ^ wide[97-t] ^ wide[91-t];
    end
  end

  // After 64 steps the high word is the old low word; the low word holds the
  // 64 fed-back bits, which all come from old bits 27 to 96 of both words.
  always_comb begin
    state_next.long_high = state.long_low;
    for (int j = 0; j < WORD_W; j++) begin
      state_next.long_low[j] = wide[33+j] ^ wide[27+j];
    end
    for (int j = 0; j < SHORT_W; j++) begin
      state_next.short_reg[j] = ^(SHORT_MASKS[SHORT_STREAM_LEN-1-j] & state.short_reg);
    end
  end

endmodule

### rtl/dlks_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlks_checker
// Port-level checks of the cipher's output register and handshakes.
// ----------------------------------------------------------------------------
module dlks_checker
  import dlks_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              s_tvalid,
  input logic              s_tready,
  input logic              m_tvalid,
  input logic              m_tready,
  input logic [WORD_W-1:0] m_tdata
);

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  // Every accepted beat shows up on the output in the next cycle.
  a_one_cycle: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> m_tvalid)
    else $error("accepted beat not presented");

  // A waiting output blocks the input side.
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !s_tready)
    else $error("input taken while output stalled");

  // With nothing new accepted, a taken beat leaves the output empty.
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !(s_tvalid && s_tready)) |=> !m_tvalid)
    else $error("beat repeated on output");

  // A stalled beat holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled output beat changed");

endmodule

bind dual_lfsr_keystream_cipher dlks_checker u_dlks_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
